### hw/rtl/otc_pkg.sv
// Shared types and constants for the oscillator trim calibrator.
// Used by otc_ctrl, otc_dp and oscillator_trim_calibrator; no dependencies.

package otc_pkg;

    localparam int CAP_W   = 16;
    localparam int TRIM_W  = 7;
    localparam int CODE_W  = 8;
    localparam int FLAG_W  = 5;
    localparam int BAND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int OUT_W   = 48;

    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NONMONO  = 8'hC0;
    localparam logic [CODE_W-1:0] CODE_TOO_FAST = 8'h80;
    localparam logic [CODE_W-1:0] CODE_TOO_SLOW = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_END_TO   = 8'hD0;
    localparam logic [CODE_W-1:0] CODE_SWEEP_TO = 8'hE0;

    localparam logic [TRIM_W-1:0] TRIM_TOP      = 7'h7F;
    localparam logic [TRIM_W-1:0] FALLBACK_TRIM = 7'h40;
    localparam logic [CAP_W-1:0]  TIMEOUT_COUNT = 16'hFFFF;
    localparam logic [CAP_W-1:0]  TARGET_RESET  = 16'd7812;
    localparam logic [7:0]        TIMEOUT_SAT   = 8'hFF;

    localparam logic [FLAG_W-1:0] FLAG_NONMONO  = 5'h01;
    localparam logic [FLAG_W-1:0] FLAG_TOO_FAST = 5'h02;
    localparam logic [FLAG_W-1:0] FLAG_TOO_SLOW = 5'h04;
    localparam logic [FLAG_W-1:0] FLAG_END_TO   = 5'h08;
    localparam logic [FLAG_W-1:0] FLAG_SWEEP_TO = 5'h10;

    localparam logic [3:0] FIRST_SUMMED = 4'd3;
    localparam logic [3:0] LAST_CAPTURE = 4'd10;

    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_BAND   = 1'b1;

    typedef struct packed {
        logic capture;
        logic step;
        logic div_step;
        logic win;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } dp_status_t;

    function automatic logic [TRIM_W-1:0] applied_of(input logic [CODE_W-1:0] code);
        logic [TRIM_W-1:0] res;
        res = code[CODE_W-1] ? FALLBACK_TRIM : code[TRIM_W-1:0];
        return res;
    endfunction

endpackage

### hw/rtl/otc_ctrl.sv
// Sequencing state machine of the oscillator trim calibrator.
// Depends on otc_pkg; drives the commands of otc_dp.

module otc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  otc_pkg::dp_status_t   status,
    output otc_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WIN,
        ST_EMIT
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [otc_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [otc_pkg::DIV_CNT_W-1:0]  cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.step = 1'b1;
                if (status.need_div)
                begin
                    cnt_next   = otc_pkg::DIV_CNT_W'(otc_pkg::DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_WIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_WIN:
            begin
                cmd.win    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/otc_dp.sv
// Datapath of the oscillator trim calibrator: measurement state, sweep state,
// the iterative estimate divider and the result register. Depends on otc_pkg.

module otc_dp
#(
    parameter int WIN_RADIUS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  otc_pkg::ctrl_cmd_t            cmd,
    output otc_pkg::dp_status_t           status,
    input  logic [otc_pkg::CAP_W-1:0]     s_tdata,
    input  logic [otc_pkg::MODE_W-1:0]    s_tuser,
    input  logic [otc_pkg::CAP_W-1:0]     target_count,
    input  logic [otc_pkg::BAND_W-1:0]    freq_band,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [otc_pkg::OUT_W-1:0]     m_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LOW   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_SWEEP = 3'd3,
        PH_FINAL = 3'd4
    } phase_t;

    localparam int CW = otc_pkg::CAP_W;
    localparam int TW = otc_pkg::TRIM_W;

    logic [otc_pkg::MODE_W-1:0] mode_reg;
    logic [CW-1:0]              cap_reg;

    phase_t                     phase_reg, phase_next;
    logic [3:0]                 cidx_reg, cidx_next;
    logic [18:0]                csum_reg, csum_next;
    logic [1:0]                 tick_reg, tick_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [7:0]                 tot_reg, tot_next;
    logic [TW-1:0]              send_reg, send_next;
    logic [TW-1:0]              trim_reg, trim_next;
    logic [CW-1:0]              lerr_reg, lerr_next;
    logic [otc_pkg::CODE_W-1:0] best_reg, best_next;
    logic [otc_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic [CW-1:0]              last_reg, last_next;
    logic                       done_reg, done_next;

    logic [CW:0]                rem_reg, rem_next;
    logic [7:0]                 quo_reg, quo_next;

    logic                       out_valid_reg;
    logic [otc_pkg::OUT_W-1:0]  out_data_reg;

    logic                       need_div;
    logic                       active;
    logic                       meas_done;
    logic [CW-1:0]              meas_val;
    logic [1:0]                 tick_inc;
    logic [CW-1:0]              err;
    logic [CW:0]                div_d;
    logic [7:0]                 est;
    logic [8:0]                 lo_w;
    logic [8:0]                 hi_w;

    always_comb
    begin
        phase_next = phase_reg;
        cidx_next  = cidx_reg;
        csum_next  = csum_reg;
        tick_next  = tick_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tot_next   = tot_reg;
        send_next  = send_reg;
        trim_next  = trim_reg;
        lerr_next  = lerr_reg;
        best_next  = best_reg;
        flags_next = flags_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        need_div   = 1'b0;
        meas_done  = 1'b0;
        meas_val   = '0;
        tick_inc   = tick_reg + 2'd1;
        err        = '0;
        div_d      = {1'b0, hi_reg - lo_reg};
        est        = (hi_reg == lo_reg) ? 8'd0 : quo_reg;
        lo_w       = '0;
        hi_w       = '0;

        unique case (phase_reg)
            PH_LOW, PH_HIGH, PH_SWEEP, PH_FINAL: active = 1'b1;
            default:                            active = 1'b0;
        endcase

        if (cmd.step)
        begin
            unique case (mode_reg)
                otc_pkg::MODE_START:
                begin
                    flags_next = '0;
                    best_next  = '0;
                    tot_next   = '0;
                    trim_next  = '0;
                    phase_next = PH_LOW;
                    cidx_next  = '0;
                    csum_next  = '0;
                    tick_next  = '0;
                end
                otc_pkg::MODE_CAPTURE:
                begin
                    if (active)
                    begin
                        if (cidx_reg >= otc_pkg::FIRST_SUMMED)
                        begin
                            csum_next = csum_reg + {3'b000, cap_reg};
                        end
                        if (cidx_reg >= otc_pkg::LAST_CAPTURE)
                        begin
                            meas_done = 1'b1;
                            meas_val  = csum_next[18:3];
                        end
                        else
                        begin
                            cidx_next = cidx_reg + 4'd1;
                        end
                    end
                end
                otc_pkg::MODE_TICK:
                begin
                    if (active)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= 2'd2)
                        begin
                            if (tot_reg != otc_pkg::TIMEOUT_SAT)
                            begin
                                tot_next = tot_reg + 8'd1;
                            end
                            meas_done = 1'b1;
                            meas_val  = otc_pkg::TIMEOUT_COUNT;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (meas_done)
            begin
                last_next = meas_val;
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        lo_next    = meas_val;
                        trim_next  = otc_pkg::TRIM_TOP;
                        phase_next = PH_HIGH;
                        cidx_next  = '0;
                        csum_next  = '0;
                        tick_next  = '0;
                    end
                    PH_HIGH:
                    begin
                        hi_next    = meas_val;
                        flags_next = '0;
                        if (lo_reg > meas_val)
                        begin
                            flags_next = flags_next | otc_pkg::FLAG_NONMONO;
                            best_next  = otc_pkg::CODE_NONMONO;
                        end
                        if (lo_reg > target_count)
                        begin
                            flags_next = flags_next | otc_pkg::FLAG_TOO_FAST;
                            best_next  = otc_pkg::CODE_TOO_FAST;
                        end
                        if (meas_val < target_count)
                        begin
                            flags_next = flags_next | otc_pkg::FLAG_TOO_SLOW;
                            best_next  = otc_pkg::CODE_TOO_SLOW;
                        end
                        if (tot_next != '0)
                        begin
                            flags_next = flags_next | otc_pkg::FLAG_END_TO;
                            best_next  = otc_pkg::CODE_END_TO;
                        end
                        if (flags_next != '0)
                        begin
                            trim_next  = otc_pkg::applied_of(best_next);
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            need_div = 1'b1;
                            rem_next = {1'b0, target_count - lo_reg};
                            quo_next = '0;
                        end
                    end
                    PH_SWEEP:
                    begin
                        err = (meas_val >= target_count) ? meas_val - target_count
                                                         : target_count - meas_val;
                        if (err < lerr_reg)
                        begin
                            lerr_next = err;
                            best_next = {1'b0, trim_reg};
                        end
                        if (trim_reg >= send_reg || trim_reg >= otc_pkg::TRIM_TOP)
                        begin
                            trim_next  = best_next[TW-1:0];
                            phase_next = PH_FINAL;
                        end
                        else
                        begin
                            trim_next = trim_reg + 1'b1;
                        end
                        cidx_next = '0;
                        csum_next = '0;
                        tick_next = '0;
                    end
                    default:
                    begin
                        if (tot_next != '0)
                        begin
                            flags_next = flags_reg | otc_pkg::FLAG_SWEEP_TO;
                            best_next  = otc_pkg::CODE_SWEEP_TO;
                        end
                        trim_next  = otc_pkg::applied_of(best_next);
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
        end

        if (cmd.div_step)
        begin
            if (rem_reg >= div_d)
            begin
                rem_next = (rem_reg - div_d) << 1;
                quo_next = {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_next = rem_reg << 1;
                quo_next = {quo_reg[6:0], 1'b0};
            end
        end

        if (cmd.win)
        begin
            lo_w = ({1'b0, est} >= 9'(WIN_RADIUS)) ? {1'b0, est} - 9'(WIN_RADIUS) : 9'd0;
            hi_w = {1'b0, est} + 9'(WIN_RADIUS);
            if (hi_w >= {2'b00, otc_pkg::TRIM_TOP})
            begin
                hi_w = {2'b00, otc_pkg::TRIM_TOP};
            end
            if (lo_w > {2'b00, otc_pkg::TRIM_TOP})
            begin
                lo_w = {2'b00, otc_pkg::TRIM_TOP};
            end
            send_next  = hi_w[TW-1:0];
            tot_next   = '0;
            lerr_next  = otc_pkg::TIMEOUT_COUNT;
            best_next  = {1'b0, lo_w[TW-1:0]};
            trim_next  = lo_w[TW-1:0];
            phase_next = PH_SWEEP;
            cidx_next  = '0;
            csum_next  = '0;
            tick_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cidx_reg  <= '0;
            csum_reg  <= '0;
            tick_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            tot_reg   <= '0;
            send_reg  <= '0;
            trim_reg  <= '0;
            lerr_reg  <= otc_pkg::TIMEOUT_COUNT;
            best_reg  <= '0;
            flags_reg <= '0;
            last_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cidx_reg  <= cidx_next;
            csum_reg  <= csum_next;
            tick_reg  <= tick_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            tot_reg   <= tot_next;
            send_reg  <= send_next;
            trim_reg  <= trim_next;
            lerr_reg  <= lerr_next;
            best_reg  <= best_next;
            flags_reg <= flags_next;
            last_reg  <= last_next;
            if (cmd.step)
            begin
                done_reg <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.capture)
        begin
            mode_reg <= s_tuser;
            cap_reg  <= s_tdata;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {1'b0, freq_band, last_reg,
                             otc_pkg::applied_of(best_reg), flags_reg, best_reg,
                             done_reg, (phase_reg != PH_IDLE), trim_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status   = '{need_div: need_div, out_free: (!out_valid_reg || m_tready)};
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/oscillator_trim_calibrator.sv
// Top level of the oscillator trim calibrator: configuration registers and the
// controller and datapath. Depends on otc_pkg, otc_ctrl and otc_dp.
//
//   Channel   Direction  Handshake                Contents
//   s_*       in         s_tvalid / s_tready      capture_value, mode
//   m_*       out        m_tvalid / m_tready      one result per input transaction
//   APB       in         psel, penable, pwrite    target_count at 0, freq_band at 4
//
// A result is loaded into the output register after its transaction is accepted
// and one step executes; the item that ends the trim 127 measurement without a
// fault also runs the 8 steps of the estimate divider and the window setup
// first. The next item is taken once the result is in the output register.
// Reset is asynchronous and needs no clearing pass. A stalled output holds the
// next result in the datapath until the output register frees up.

module oscillator_trim_calibrator
#(
    parameter int WIN_RADIUS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] trim_setting, [7] busy_res, [8] done_res,
                                   // [16:9] result_code, [21:17] status_flags,
                                   // [28:22] applied_trim, [44:29] measured_count,
                                   // [46:45] band_select, [47] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [otc_pkg::CAP_W-1:0]  target_reg;
    logic [otc_pkg::BAND_W-1:0] band_reg;
    logic                       cfg_wr;
    otc_pkg::ctrl_cmd_t         cmd;
    otc_pkg::dp_status_t        status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= otc_pkg::TARGET_RESET;
            band_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                otc_pkg::REG_TARGET: target_reg <= pwdata[otc_pkg::CAP_W-1:0];
                otc_pkg::REG_BAND:   band_reg   <= pwdata[otc_pkg::BAND_W-1:0];
                default:             target_reg <= target_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            otc_pkg::REG_TARGET: prdata = {16'd0, target_reg};
            otc_pkg::REG_BAND:   prdata = {30'd0, band_reg};
            default:             prdata = '0;
        endcase
    end

    otc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    otc_dp
    #(
        .WIN_RADIUS (WIN_RADIUS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .target_count (target_reg),
        .freq_band    (band_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
